>>> rtl/rmps_pkg.sv
// ----------------------------------------------------------------------------
// rmps_pkg
// Types shared by the rate monotonic priority sorter and its chain cells.
// ----------------------------------------------------------------------------
package rmps_pkg;

   localparam int TAG_W    = 16;
   localparam int PERIOD_W = 32;

   typedef struct packed {
      logic [TAG_W-1:0]    task_tag;
      logic [PERIOD_W-1:0] task_period;
      logic                last_entry;
   } req_type;

   typedef struct packed {
      logic [TAG_W-1:0]    out_tag;
      logic [PERIOD_W-1:0] out_period;
      logic                out_last;
      logic                overflow;
   } rsp_type;

   typedef struct packed {
      logic                valid;
      logic [TAG_W-1:0]    tag;
      logic [PERIOD_W-1:0] period;
   } entry_type;

   typedef struct packed {
      logic load;
      logic unload;
      logic by_period;
   } cell_ctrl_type;

   typedef enum logic {
      ST_LOAD,
      ST_EMIT
   } state_type;

endpackage

>>> rtl/rmps_cell.sv
// ----------------------------------------------------------------------------
// rmps_cell
// One insertion cell: keeps its entry, takes the new entry, or takes the
// entry of a neighbor (upstream while loading, downstream while unloading).
// ----------------------------------------------------------------------------
module rmps_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  rmps_pkg::cell_ctrl_type ctrl,
   input  rmps_pkg::entry_type    new_entry,
   input  logic                   prev_keep,
   input  rmps_pkg::entry_type    prev_entry,
   input  rmps_pkg::entry_type    next_entry,
   output logic                   keep,
   output rmps_pkg::entry_type    entry
);
   import rmps_pkg::*;

   entry_type entry_ff;
   entry_type entry_in;

   always_comb begin
      keep = entry_ff.valid &
             (!ctrl.by_period || (entry_ff.period >= new_entry.period));
   end

   always_comb begin
      entry_in = entry_ff;
      if (ctrl.unload) begin
         entry_in = next_entry;
      end else if (ctrl.load) begin
         priority if (keep) begin
            entry_in = entry_ff;
         end else if (prev_keep) begin
            entry_in = new_entry;
         end else begin
            entry_in = prev_entry;
         end
      end
   end

   always_ff @(posedge clock) begin
      entry_ff.tag    <= entry_in.tag;
      entry_ff.period <= entry_in.period;
      if (reset) begin
         entry_ff.valid <= 1'b0;
      end else begin
         entry_ff.valid <= entry_in.valid;
      end
   end

   assign entry = entry_ff;

endmodule

>>> rtl/rate_monotonic_priority_sorter_core.sv
// ----------------------------------------------------------------------------
// rate_monotonic_priority_sorter_core
// Loads task entries into an insertion chain, one transaction per cycle,
// then emits them from the head of the chain by decreasing period, or in
// load order when sort_mode is 0. Results start the cycle after the
// marked entry, one per cycle. Throughput: one entry per cycle while
// loading; busy stays high while the chain shifts out through cell 0.
// Reset: chain empty, counter and overflow cleared, sort_mode set to 1.
// The receiver cannot stall; each result shows for exactly one cycle.
// ----------------------------------------------------------------------------
module rate_monotonic_priority_sorter_core #(
   parameter int MAX_TASKS = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  rmps_pkg::req_type req_data,
   output logic              rsp_valid,
   output rmps_pkg::rsp_type rsp_data,
   input  logic              csr_wr_en,
   input  logic              csr_wr_data
);
   import rmps_pkg::*;

   localparam int CNT_W = $clog2(MAX_TASKS + 1);

   state_type       state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic            dropped_ff, dropped_in;
   logic            sort_mode_ff;

   logic            accept;
   logic            full;
   cell_ctrl_type   ctrl;
   entry_type       new_entry;
   entry_type       cell_entry [MAX_TASKS];
   logic            cell_keep  [MAX_TASKS];
   entry_type       empty_entry;

   assign accept = start && !busy;
   assign full   = (count_ff == CNT_W'(MAX_TASKS));

   assign new_entry.valid  = 1'b1;
   assign new_entry.tag    = req_data.task_tag;
   assign new_entry.period = req_data.task_period;

   assign empty_entry = '0;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_LOAD: begin
            if (accept && req_data.last_entry) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (count_ff == CNT_W'(1)) begin
               state_in = ST_LOAD;
            end
         end
         default: state_in = ST_LOAD;
      endcase
   end

   // outputs and chain control
   always_comb begin
      busy           = 1'b0;
      rsp_valid      = 1'b0;
      ctrl.load      = 1'b0;
      ctrl.unload    = 1'b0;
      ctrl.by_period = sort_mode_ff;
      count_in       = count_ff;
      dropped_in     = dropped_ff;
      unique case (state_ff)
         ST_LOAD: begin
            if (accept) begin
               if (full) begin
                  dropped_in = 1'b1;
               end else begin
                  ctrl.load = 1'b1;
                  count_in  = count_ff + CNT_W'(1);
               end
            end
         end
         ST_EMIT: begin
            busy        = 1'b1;
            rsp_valid   = 1'b1;
            ctrl.unload = 1'b1;
            count_in    = count_ff - CNT_W'(1);
            if (count_ff == CNT_W'(1)) begin
               dropped_in = 1'b0;
            end
         end
         default: begin
            busy = 1'b0;
         end
      endcase
   end

   assign rsp_data.out_tag    = cell_entry[0].tag;
   assign rsp_data.out_period = cell_entry[0].period;
   assign rsp_data.out_last   = (count_ff == CNT_W'(1));
   assign rsp_data.overflow   = dropped_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         count_ff     <= '0;
         dropped_ff   <= 1'b0;
         sort_mode_ff <= 1'b1;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         dropped_ff <= dropped_in;
         if (csr_wr_en) begin
            sort_mode_ff <= csr_wr_data;
         end
      end
   end

   for (genvar i = 0; i < MAX_TASKS; i++) begin : g_cell
      logic      prev_keep;
      entry_type prev_entry;
      entry_type next_entry;

      if (i == 0) begin : g_head
         assign prev_keep  = 1'b1;
         assign prev_entry = empty_entry;
      end else begin : g_body
         assign prev_keep  = cell_keep[i-1];
         assign prev_entry = cell_entry[i-1];
      end

      if (i == MAX_TASKS - 1) begin : g_tail
         assign next_entry = empty_entry;
      end else begin : g_mid
         assign next_entry = cell_entry[i+1];
      end

      rmps_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .new_entry  (new_entry),
         .prev_keep  (prev_keep),
         .prev_entry (prev_entry),
         .next_entry (next_entry),
         .keep       (cell_keep[i]),
         .entry      (cell_entry[i])
      );
   end

endmodule

>>> dv/rmps_scoreboard_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmps_scoreboard_pkg
// Priority order predictor and scoreboard for the rate monotonic sorter.
// Accepted task entries are held in load order. The marked entry of a set
// releases the whole set: it is ordered by decreasing period with ties kept
// in load order (or left in load order when sorting is off), and the set is
// queued as expected results that are checked field by field as they arrive.
// ----------------------------------------------------------------------------
package rmps_scoreboard_pkg;
   import rmps_pkg::*;

   localparam int SORTER_DEPTH = 32;

   class priority_order_scoreboard;
      bit [TAG_W-1:0]    held_tag[SORTER_DEPTH];
      bit [PERIOD_W-1:0] held_period[SORTER_DEPTH];
      int                held_count;
      bit                dropped;
      bit                by_period;
      rsp_type           expected_order[$];
      int unsigned       error_count;

      function new();
         held_count  = 0;
         dropped     = 1'b0;
         by_period   = 1'b1;
         error_count = 0;
      endfunction

      function void set_mode(input bit mode);
         by_period = mode;
      endfunction

      function int pending();
         return expected_order.size();
      endfunction

      function void note_entry(input req_type entry);
         int      rank[SORTER_DEPTH];
         int      i;
         int      p;
         rsp_type slot;
         if (held_count < SORTER_DEPTH) begin
            held_tag[held_count]    = entry.task_tag;
            held_period[held_count] = entry.task_period;
            held_count++;
         end else begin
            dropped = 1'b1;
         end
         if (!entry.last_entry) return;
         // stable insertion: a new entry goes after every entry of equal or longer period
         for (i = 0; i < held_count; i++) begin
            p = i;
            if (by_period) begin
               while (p > 0 && held_period[rank[p-1]] < held_period[i]) begin
                  rank[p] = rank[p-1];
                  p--;
               end
            end
            rank[p] = i;
         end
         for (i = 0; i < held_count; i++) begin
            slot.out_tag    = held_tag[rank[i]];
            slot.out_period = held_period[rank[i]];
            slot.out_last   = (i == held_count - 1);
            slot.overflow   = dropped;
            expected_order.push_back(slot);
         end
         held_count = 0;
         dropped    = 1'b0;
      endfunction

      function void report_field(input string field, input logic [31:0] want,
                                 input logic [31:0] got);
         $display("%0t: %s mismatch, expected %h actual %h", $time, field, want, got);
         error_count++;
      endfunction

      function void check_result(input rsp_type got);
         rsp_type want;
         if (expected_order.size() == 0) begin
            $display("%0t: result with none expected, actual %h", $time, got);
            error_count++;
            return;
         end
         want = expected_order.pop_front();
         if (got.out_tag !== want.out_tag)
            report_field("out_tag", 32'(want.out_tag), 32'(got.out_tag));
         if (got.out_period !== want.out_period)
            report_field("out_period", want.out_period, got.out_period);
         if (got.out_last !== want.out_last)
            report_field("out_last", 32'(want.out_last), 32'(got.out_last));
         if (got.overflow !== want.overflow)
            report_field("overflow", 32'(want.overflow), 32'(got.overflow));
      endfunction
   endclass

endpackage

>>> dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the rate monotonic priority sorter core.
// Drives task sets through the start/busy port, directed sets first (single
// entries, period and tag extremes, equal periods, both modes), then random
// sets of mixed size including full and overflowing stores. The sort mode is
// changed only between drained phases; every emitted transaction is checked
// against the scoreboard and a watchdog ends a stalled run.
// ----------------------------------------------------------------------------
module tb_top;
   import rmps_pkg::*;
   import rmps_scoreboard_pkg::*;

   localparam int STALL_LIMIT   = 2000;
   localparam int ITEMS_PER_SEG = 58;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_valid;
   rsp_type rsp_data;
   logic    csr_wr_en;
   logic    csr_wr_data;

   priority_order_scoreboard sb;
   int unsigned              stall_cycles;

   rate_monotonic_priority_sorter_core #(
      .MAX_TASKS(SORTER_DEPTH)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_data   (rsp_data),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid) sb.check_result(rsp_data);
         if (start && !busy) sb.note_entry(req_data);
         if (rsp_valid || (start && !busy)) stall_cycles = 0;
         else stall_cycles++;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

   task automatic send_entry(input req_type entry);
      @(negedge clock);
      start    <= 1'b1;
      req_data <= entry;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic hold_off(input int unsigned idle_pct);
      while ($urandom_range(99, 0) < idle_pct) begin
         @(negedge clock);
         start <= 1'b0;
      end
   endtask

   task automatic wait_drained(input int unsigned settle);
      @(negedge clock);
      start <= 1'b0;
      while (sb.pending() != 0) @(negedge clock);
      repeat (settle) @(negedge clock);
   endtask

   task automatic write_mode(input bit mode);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= mode;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      sb.set_mode(mode);
   endtask

   function automatic logic [PERIOD_W-1:0] pick_period();
      case ($urandom_range(9, 0))
         0:       return '0;
         1:       return '1;
         2, 3, 4: return $urandom_range(7, 0);
         default: return $urandom;
      endcase
   endfunction

   function automatic int unsigned pick_size();
      int unsigned roll;
      roll = $urandom_range(99, 0);
      if (roll < 70) return $urandom_range(6, 1);
      if (roll < 88) return $urandom_range(SORTER_DEPTH - 1, 7);
      return $urandom_range(SORTER_DEPTH + 8, SORTER_DEPTH);
   endfunction

   task automatic send_set(input int unsigned size, input int unsigned idle_pct);
      req_type entry;
      for (int unsigned i = 0; i < size; i++) begin
         hold_off(idle_pct);
         entry.task_tag    = 16'($urandom);
         entry.task_period = pick_period();
         entry.last_entry  = (i == size - 1);
         send_entry(entry);
      end
   endtask

   initial begin
      int unsigned sent;
      int unsigned size;
      int unsigned idle_pct;
      bit          first_set;
      sb           = new();
      reset        = 1'b1;
      start        = 1'b0;
      req_data     = '0;
      csr_wr_en    = 1'b0;
      csr_wr_data  = 1'b0;
      stall_cycles = 0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // sorted: single entry, then ties and extremes
      write_mode(1'b1);
      send_entry({16'hFFFF, 32'hFFFF_FFFF, 1'b1});
      send_entry({16'h0000, 32'd5, 1'b0});
      send_entry({16'h0001, 32'd0, 1'b0});
      send_entry({16'hFFFF, 32'd5, 1'b0});
      send_entry({16'h0002, 32'hFFFF_FFFF, 1'b0});
      send_entry({16'h0003, 32'd0, 1'b0});
      send_entry({16'h0004, 32'd5, 1'b0});
      send_entry({16'h0005, 32'h8000_0000, 1'b1});
      wait_drained(4);

      // load order
      write_mode(1'b0);
      send_entry({16'h0000, 32'd0, 1'b0});
      send_entry({16'hFFFF, 32'hFFFF_FFFF, 1'b0});
      send_entry({16'hA5A5, 32'd7, 1'b0});
      send_entry({16'h5A5A, 32'd7, 1'b1});
      send_entry({16'h0000, 32'd0, 1'b1});

      for (int seg = 0; seg < 6; seg++) begin
         wait_drained(4);
         write_mode(seg % 2 == 0);
         idle_pct  = (seg / 2 == 0) ? 37 : (seg / 2 == 1) ? 51 : 0;
         sent      = 0;
         first_set = 1'b1;
         while (sent < ITEMS_PER_SEG) begin
            size = pick_size();
            if (first_set && seg == 1) size = SORTER_DEPTH + 1;
            if (first_set && seg == 2) size = SORTER_DEPTH + 3;
            if (first_set && seg == 4) size = SORTER_DEPTH;
            first_set = 1'b0;
            send_set(size, idle_pct);
            sent += size;
            if ($urandom_range(5, 0) == 0) wait_drained(1);
         end
      end

      wait_drained(10);
      if (sb.error_count == 0 && sb.pending() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

>>> rate_monotonic_priority_sorter_core.f
rtl/rmps_pkg.sv
rtl/rmps_cell.sv
rtl/rate_monotonic_priority_sorter_core.sv
dv/rmps_scoreboard_pkg.sv
dv/tb_top.sv
